[hdl/swlrl_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding-window-log rate limiter: shared package
// Field widths, register indexes, defaults and the request type passed from
// the front queue to the back engine.
// ----------------------------------------------------------------------------
package swlrl_pkg;

    localparam int TIME_W      = 32;
    localparam int WINDOW_W    = 16;
    localparam int MAX_W       = 4;
    localparam int COUNT_OUT_W = 5;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int DEPTH_DEF   = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SECONDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS   = 1'b1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd5;
    localparam logic [MAX_W-1:0]    MAX_RESET    = 4'd3;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] stamp;
    } req_t;

endpackage

[hdl/swlrl_front.sv]
// ----------------------------------------------------------------------------
// Sliding-window-log rate limiter: front queue
// Accepts attempts from the input channel and holds them in a short queue
// until the back engine is ready to take the next one.
// ----------------------------------------------------------------------------
module swlrl_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [swlrl_pkg::TIME_W-1:0] s_attempt_time,
    output swlrl_pkg::req_t              req,
    input  logic                         req_ready
);

    localparam int QD = swlrl_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(QD);
    localparam int CW = $clog2(QD + 1);

    logic [swlrl_pkg::TIME_W-1:0] entry_reg [QD];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          push, pop;

    assign s_ready   = (fill_reg != CW'(QD));
    assign push      = s_valid && s_ready;
    assign pop       = req.valid && req_ready;
    assign req.valid = (fill_reg != '0);
    assign req.stamp = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= s_attempt_time;
        end
    end

endmodule

[hdl/swlrl_engine.sv]
// ----------------------------------------------------------------------------
// Sliding-window-log rate limiter: back engine
// Records each attempt in the timestamp ring, pops expired entries one at a
// time via a read and a check state, and registers the result for output.
// ----------------------------------------------------------------------------
module swlrl_engine #(
    parameter int DEPTH = swlrl_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  swlrl_pkg::req_t                   req,
    output logic                              req_ready,
    input  logic [swlrl_pkg::WINDOW_W-1:0]    window_seconds,
    input  logic [swlrl_pkg::MAX_W-1:0]       max_attempts,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_allowed,
    output logic [swlrl_pkg::COUNT_OUT_W-1:0] m_recent_count,
    output logic                              m_overflow
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = swlrl_pkg::TIME_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_CHECK = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TW-1:0] now_reg, now_next;
    logic          ovf_reg, ovf_next;
    logic [TW-1:0] rd_data_reg;
    logic [TW-1:0] ring [DEPTH];

    logic          out_valid_reg, out_valid_next;
    logic          out_allowed_reg, out_allowed_next;
    logic [swlrl_pkg::COUNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [IW-1:0] oldest_inc;
    logic [IW:0]   pos_sum;
    logic [IW-1:0] pos;
    logic [TW-1:0] age;

    assign oldest_inc = (oldest_reg == IW'(DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    assign pos_sum    = {1'b0, oldest_reg} + (IW + 1)'(count_reg);
    assign pos        = (pos_sum >= (IW + 1)'(DEPTH)) ?
                        IW'(pos_sum - (IW + 1)'(DEPTH)) : pos_sum[IW-1:0];
    assign age        = now_reg - rd_data_reg;

    always_comb begin
        state_next       = state_reg;
        oldest_next      = oldest_reg;
        count_next       = count_reg;
        now_next         = now_reg;
        ovf_next         = ovf_reg;
        req_ready        = 1'b0;
        mem_we           = 1'b0;
        mem_wa           = pos;
        out_valid_next   = out_valid_reg;
        out_allowed_next = out_allowed_reg;
        out_count_next   = out_count_reg;
        out_ovf_next     = out_ovf_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (req.valid) begin
                    req_ready  = 1'b1;
                    mem_we     = 1'b1;
                    now_next   = req.stamp;
                    state_next = ST_READ;
                    if (count_reg == CW'(DEPTH)) begin
                        mem_wa      = oldest_reg;
                        oldest_next = oldest_inc;
                        ovf_next    = 1'b1;
                    end else begin
                        mem_wa     = pos;
                        count_next = count_reg + 1'b1;
                        ovf_next   = 1'b0;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (age > TW'(window_seconds)) begin
                    oldest_next = oldest_inc;
                    count_next  = count_reg - 1'b1;
                    state_next  = ST_READ;
                end else if (!out_valid_reg || m_ready) begin
                    out_valid_next   = 1'b1;
                    out_allowed_next = ((CW + 4)'(count_reg) <= (CW + 4)'(max_attempts));
                    out_count_next   = swlrl_pkg::COUNT_OUT_W'(count_reg);
                    out_ovf_next     = ovf_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg         <= now_next;
        ovf_reg         <= ovf_next;
        out_allowed_reg <= out_allowed_next;
        out_count_reg   <= out_count_next;
        out_ovf_reg     <= out_ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ring[mem_wa] <= now_next;
        end
        rd_data_reg <= ring[oldest_reg];
    end

    assign m_valid        = out_valid_reg;
    assign m_allowed      = out_allowed_reg;
    assign m_recent_count = out_count_reg;
    assign m_overflow     = out_ovf_reg;

endmodule

[hdl/sliding_window_log_rate_limiter.sv]
// ----------------------------------------------------------------------------
// Sliding-window-log rate limiter: top level
// Each attempt timestamp is logged in a ring; entries older than the window
// are dropped and the attempt is allowed while the kept count stays within
// the configured maximum.
//
// The input channel (s_valid, s_ready, s_attempt_time) carries one attempt
// per transfer into a two-entry queue. The output channel (m_valid, m_ready,
// m_allowed, m_recent_count, m_overflow) returns exactly one result per
// attempt, in order. The back engine takes one attempt at a time: it logs
// it in the ring, then reads and checks the oldest ring entry, dropping it
// and repeating the read and check while that entry has expired; the ring
// has a single memory read port. A result is registered once no expired
// entry is left and the output register is free or being read.
// A stalled receiver holds the result in the output register; the engine
// then waits and the queue keeps taking attempts until it is full.
// Reset empties the queue and the ring, clears any pending result and sets
// window_seconds to 5 and max_attempts to 3. The user must write registers
// via cfg_we, cfg_index, cfg_data only while idle; the block does not check.
// ----------------------------------------------------------------------------
module sliding_window_log_rate_limiter #(
    parameter int DEPTH = swlrl_pkg::DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [swlrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swlrl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [swlrl_pkg::TIME_W-1:0]        s_attempt_time,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_allowed,
    output logic [swlrl_pkg::COUNT_OUT_W-1:0]   m_recent_count,
    output logic                                m_overflow
);

    logic [swlrl_pkg::WINDOW_W-1:0] window_reg, window_next;
    logic [swlrl_pkg::MAX_W-1:0]    max_reg, max_next;
    swlrl_pkg::req_t                req;
    logic                           req_ready;

    always_comb begin
        window_next = window_reg;
        max_next    = max_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                swlrl_pkg::CFG_WINDOW_SECONDS: begin
                    window_next = cfg_data[swlrl_pkg::WINDOW_W-1:0];
                end
                swlrl_pkg::CFG_MAX_ATTEMPTS: begin
                    max_next = cfg_data[swlrl_pkg::MAX_W-1:0];
                end
                default: begin
                    window_next = window_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= swlrl_pkg::WINDOW_RESET;
            max_reg    <= swlrl_pkg::MAX_RESET;
        end else begin
            window_reg <= window_next;
            max_reg    <= max_next;
        end
    end

    swlrl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_attempt_time (s_attempt_time),
        .req            (req),
        .req_ready      (req_ready)
    );

    swlrl_engine #(
        .DEPTH (DEPTH)
    ) u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (req),
        .req_ready      (req_ready),
        .window_seconds (window_reg),
        .max_attempts   (max_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_allowed      (m_allowed),
        .m_recent_count (m_recent_count),
        .m_overflow     (m_overflow)
    );

endmodule
